// ----- src/mpfd_pkg.sv -----
`default_nettype none
package mpfd_pkg;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_PIXEL = 2'd1,
    KIND_BOX   = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic        CFG_ROTATE_IDX = 1'b0;

endpackage
`default_nettype wire

// ----- src/mpfd_ram.sv -----
`default_nettype none
module mpfd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- src/mono_page_framebuffer_draw_core.sv -----
// Drawing engine for a COLUMNS x (PAGES*8) one-bit framebuffer kept in pages of
// eight rows, one byte per column, in a single synchronous RAM. A command is taken
// when start is high and busy is low; every command gives exactly one result word,
// shown on the out_ ports for one cycle with out_valid, and the receiver cannot
// stall it. Clear walks all COLUMNS*PAGES bytes at one RAM write per cycle. A box
// walks the bytes it touches with one read-modify-write per cycle through the
// RAM's read and write ports; an empty or off-screen box writes nothing. After
// reset the block clears the RAM with busy high; configuration writes are taken
// meanwhile.
`default_nettype none
module mono_page_framebuffer_draw_core #(
  parameter int unsigned COLUMNS = 128,
  parameter int unsigned PAGES   = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [1:0]                      in_kind,
  input  wire logic [7:0]                      in_x_start,
  input  wire logic [7:0]                      in_y_start,
  input  wire logic [7:0]                      in_x_end,
  input  wire logic [7:0]                      in_y_end,
  input  wire logic [9:0]                      in_read_address,
  output logic                                 out_valid,
  output logic [7:0]                           out_read_data,
  output logic                                 out_was_read,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [mpfd_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                     pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  import mpfd_pkg::*;

  localparam int unsigned DEPTH = COLUMNS * PAGES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam logic [7:0]  XMAX  = 8'(COLUMNS - 1);
  localparam logic [7:0]  YMAX  = 8'(PAGES * 8 - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_FILL,
    ST_DONE,
    ST_READ,
    ST_RDATA
  } state_t;

  state_t          state_r, state_nxt;
  logic            rot_r, rot_nxt;
  logic [AW-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic            clr_cmd_r, clr_cmd_nxt;
  logic [7:0]      x0_r, x0_nxt;
  logic [7:0]      x1_r, x1_nxt;
  logic [7:0]      y0_r, y0_nxt;
  logic [7:0]      y1_r, y1_nxt;
  logic [7:0]      col_r, col_nxt;
  logic [4:0]      pg_r, pg_nxt;
  logic [AW-1:0]   rd_addr_r, rd_addr_nxt;
  logic            rd_oob_r, rd_oob_nxt;
  logic            wr_pend_r, wr_pend_nxt;
  logic [AW-1:0]   wr_addr_r, wr_addr_nxt;
  logic [7:0]      wr_mask_r, wr_mask_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_data_r, out_data_nxt;
  logic            out_rd_r, out_rd_nxt;

  logic            accept;
  logic            cfg_wr;
  logic [7:0]      xe_sel, ye_sel, x1c, y1c;
  logic [2:0]      lo_bit, hi_bit;
  logic [7:0]      mask;
  logic [AW-1:0]   byte_addr;
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [7:0]      ram_wdata, ram_rdata;

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

  assign accept = start && !busy;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign busy   = (state_r != ST_IDLE);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_ROTATE_IDX) ? {31'd0, rot_r} : 32'd0;

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;
  assign out_was_read  = out_rd_r;

  // pixel is a one by one box
  assign xe_sel = (kind_t'(in_kind) == KIND_PIXEL) ? in_x_start : in_x_end;
  assign ye_sel = (kind_t'(in_kind) == KIND_PIXEL) ? in_y_start : in_y_end;
  assign x1c    = (xe_sel > XMAX) ? XMAX : xe_sel;
  assign y1c    = (ye_sel > YMAX) ? YMAX : ye_sel;

  // bits of the current page covered by the box
  assign lo_bit = (pg_r == y0_r[7:3]) ? y0_r[2:0] : 3'd0;
  assign hi_bit = (pg_r == y1_r[7:3]) ? y1_r[2:0] : 3'd7;
  assign mask   = (8'hFF << lo_bit) & (8'hFF >> (3'd7 - hi_bit));

  always_comb begin
    if (rot_r) begin
      byte_addr = AW'((32'(PAGES - 1) - 32'(pg_r)) * 32'(COLUMNS)
                      + 32'(COLUMNS - 1) - 32'(col_r));
    end else begin
      byte_addr = AW'(32'(pg_r) * 32'(COLUMNS) + 32'(col_r));
    end
  end

  // ram ports
  always_comb begin
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = 8'd0;
    end else begin
      ram_we    = wr_pend_r;
      ram_waddr = wr_addr_r;
      ram_wdata = ram_rdata | wr_mask_r;
    end
    ram_re    = (state_r == ST_FILL) || (state_r == ST_READ);
    ram_raddr = (state_r == ST_FILL) ? byte_addr : rd_addr_r;
  end

  always_comb begin
    state_nxt     = state_r;
    rot_nxt       = rot_r;
    clr_cnt_nxt   = clr_cnt_r;
    clr_cmd_nxt   = clr_cmd_r;
    x0_nxt        = x0_r;
    x1_nxt        = x1_r;
    y0_nxt        = y0_r;
    y1_nxt        = y1_r;
    col_nxt       = col_r;
    pg_nxt        = pg_r;
    rd_addr_nxt   = rd_addr_r;
    rd_oob_nxt    = rd_oob_r;
    wr_pend_nxt   = 1'b0;
    wr_addr_nxt   = wr_addr_r;
    wr_mask_nxt   = wr_mask_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    out_rd_nxt    = out_rd_r;

    if (cfg_wr && (paddr[2] == CFG_ROTATE_IDX)) begin
      rot_nxt = pwdata[0];
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (kind_t'(in_kind))
            KIND_CLEAR: begin
              clr_cnt_nxt = '0;
              clr_cmd_nxt = 1'b1;
              state_nxt   = ST_CLEAR;
            end
            KIND_PIXEL, KIND_BOX: begin
              x0_nxt  = in_x_start;
              x1_nxt  = x1c;
              y0_nxt  = in_y_start;
              y1_nxt  = y1c;
              col_nxt = in_x_start;
              pg_nxt  = in_y_start[7:3];
              if ((in_x_start > x1c) || (in_y_start > y1c)) begin
                state_nxt = ST_DONE;
              end else begin
                state_nxt = ST_FILL;
              end
            end
            KIND_READ: begin
              rd_addr_nxt = AW'(in_read_address);
              rd_oob_nxt  = (32'(in_read_address) >= 32'(DEPTH));
              state_nxt   = ST_READ;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          state_nxt = clr_cmd_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_FILL: begin
        wr_pend_nxt = 1'b1;
        wr_addr_nxt = byte_addr;
        wr_mask_nxt = rot_r ? rev8(mask) : mask;
        if (col_r == x1_r) begin
          col_nxt = x0_r;
          if (pg_r == y1_r[7:3]) begin
            state_nxt = ST_DONE;
          end else begin
            pg_nxt = pg_r + 1'b1;
          end
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      ST_DONE: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = 8'd0;
        out_rd_nxt    = 1'b0;
        state_nxt     = ST_IDLE;
      end
      ST_READ: begin
        state_nxt = ST_RDATA;
      end
      ST_RDATA: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = rd_oob_r ? 8'd0 : ram_rdata;
        out_rd_nxt    = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      rot_r       <= 1'b0;
      clr_cnt_r   <= '0;
      clr_cmd_r   <= 1'b0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rot_r       <= rot_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_cmd_r   <= clr_cmd_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    x0_r       <= x0_nxt;
    x1_r       <= x1_nxt;
    y0_r       <= y0_nxt;
    y1_r       <= y1_nxt;
    col_r      <= col_nxt;
    pg_r       <= pg_nxt;
    rd_addr_r  <= rd_addr_nxt;
    rd_oob_r   <= rd_oob_nxt;
    wr_addr_r  <= wr_addr_nxt;
    wr_mask_r  <= wr_mask_nxt;
    out_data_r <= out_data_nxt;
    out_rd_r   <= out_rd_nxt;
  end

  mpfd_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
`default_nettype wire

// ----- src/mpfd_checker.sv -----
`default_nettype none
module mpfd_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            start,
  input wire logic                            busy,
  input wire logic [1:0]                      in_kind,
  input wire logic                            out_valid,
  input wire logic [7:0]                      out_read_data,
  input wire logic                            out_was_read,
  input wire logic                            psel,
  input wire logic                            penable,
  input wire logic                            pwrite,
  input wire logic                            pready
);

  import mpfd_pkg::*;

  logic accept;
  assign accept = start && !busy;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy low after a command word was taken");

  a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (kind_t'(in_kind) == KIND_READ) |-> ##3 (out_valid && out_was_read))
    else $error("read word not returned three cycles after the command");

  a_nonread_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_was_read |-> (out_read_data == 8'd0))
    else $error("non-read result carries data");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two result words in a row");

  a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite |-> pready)
    else $error("config write stalled");

endmodule

bind mono_page_framebuffer_draw_core mpfd_checker u_mpfd_checker (.*);
`default_nettype wire
